### rtl/serial_request_ring_controller_core_defines.svh
// assertion macros for the serial request ring controller
`ifndef SERIAL_REQUEST_RING_CONTROLLER_CORE_DEFINES_SVH
`define SERIAL_REQUEST_RING_CONTROLLER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SRRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRRC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRRC_ASSERT(label, prop, msg)
`define SRRC_ASSERT_RST(label, prop, msg)
`endif

`endif

### rtl/srrc_pkg.sv
// shared types, codes and constants of the serial request ring controller
`default_nettype none
package srrc_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int MAX_REQUEST    = 32;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0a;

  localparam logic [2:0] OP_OPEN    = 3'd0;
  localparam logic [2:0] OP_CLOSE   = 3'd1;
  localparam logic [2:0] OP_RX_BYTE = 3'd2;
  localparam logic [2:0] OP_TX_RDY  = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_WRITE   = 3'd5;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_FETCH  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_IS_OPEN  = 3'd1;
  localparam logic [2:0] ST_NOT_OPEN = 3'd2;
  localparam logic [2:0] ST_ZERO_LEN = 3'd3;
  localparam logic [2:0] ST_BUSY     = 3'd4;
  localparam logic [2:0] ST_DROPPED  = 3'd5;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  localparam logic       OFF_ZERO = 1'b0;
  localparam logic       OFF_DONE = 1'b1;

  localparam logic [1:0] DAT_ZERO = 2'd0;
  localparam logic [1:0] DAT_RX   = 2'd1;
  localparam logic [1:0] DAT_MEM  = 2'd2;

  localparam logic [1:0] CNT_ZERO   = 2'd0;
  localparam logic [1:0] CNT_DONE   = 2'd1;
  localparam logic [1:0] CNT_WANTED = 2'd2;

  typedef struct packed {
    logic       latch_in;
    logic       emit;
    logic [1:0] kind;
    logic [2:0] status;
    logic       off_sel;
    logic [1:0] data_sel;
    logic [1:0] cnt_sel;
    logic       last;
    logic       open_port;
    logic       close_port;
    logic       ring_write;
    logic       ring_read;
    logic       ring_pop;
    logic       done_inc;
    logic       start_read;
    logic       start_write;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       port_open;
    logic [1:0] mode;
    logic       ring_empty;
    logic       ring_full;
    logic       len_zero;
    logic       done_lt_wanted;
    logic       done_inc_reach;
    logic       mem_nl;
    logic       rx_nl;
    logic       slot_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/serial_request_ring_controller_core.sv
// top level of the serial request ring controller
// one serial port request engine with a receive ring
// in_*: one request per handshake; in_tuser carries the operation,
//   in_tdata carries the received byte and the requested length
// out_*: result requests; out_tlast marks the final result of an input
//   request, out_tuser carries the result kind
// a request is taken only while the sequencer is idle; its fields are registered
//   at acceptance, it is decoded in the exec state, and its first result is
//   then loaded into the result register, which drives out_tvalid; a read first
//   passes the address state, and the data state as well when the ring holds data
// later results follow one per cycle while the receiver takes them, except that
//   a read drain passes the address and data states for each ring byte, set by
//   the registered ring memory read
// the single result register lets the next result load while the current
//   one is taken; a stalled receiver holds the sequencer in place, and the
//   next input request is taken once the last result of the current one
//   sits in the result register
// reset closes the port, clears pointers, fill count and pending request;
//   the ring contents are not cleared and need no clearing pass
`default_nettype none
`include "serial_request_ring_controller_core_defines.svh"
module serial_request_ring_controller_core #(
  parameter int RING_DEPTH = srrc_pkg::RING_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // rx_byte[7:0], req_length[13:8], zero[15:14]
  input  wire logic [2:0]  in_tuser,   // op[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // status[2:0], offset[7:3], data_byte[15:8],
                                       // done_count[21:16], zero[23:22]
  output logic [1:0]       out_tuser,  // kind[1:0]
  output logic             out_tlast
);

  srrc_pkg::cmd_t cmd;
  srrc_pkg::sts_t sts;
  logic [2:0] out_status;
  logic [4:0] out_offset;
  logic [7:0] out_data_byte;
  logic [5:0] out_done_count;

  srrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srrc_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_tuser),
    .in_rx_byte     (in_tdata[7:0]),
    .in_req_length  (in_tdata[13:8]),
    .cmd            (cmd),
    .sts            (sts),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_kind       (out_tuser),
    .out_status     (out_status),
    .out_offset     (out_offset),
    .out_data_byte  (out_data_byte),
    .out_done_count (out_done_count),
    .out_last       (out_tlast)
  );

  assign out_tdata = {2'b00, out_done_count, out_data_byte, out_offset, out_status};

  `SRRC_ASSERT(a_idle_no_emit, in_tready |-> !cmd.emit, "result issued while idle")
  `SRRC_ASSERT(a_emit_slot_free, cmd.emit |-> (!out_tvalid || out_tready), "result overwritten")
  `SRRC_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready, "request overlap")
  `SRRC_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule
`default_nettype wire

### rtl/srrc_ctrl.sv
// request sequencer of the serial request ring controller
`default_nettype none
module srrc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire srrc_pkg::sts_t sts,
  output srrc_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_W_STAT   = 3'd2;
  localparam logic [2:0] S_LIVE_FIN = 3'd3;
  localparam logic [2:0] S_RD_ADDR  = 3'd4;
  localparam logic [2:0] S_RD_DATA  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          srrc_pkg::OP_OPEN: begin
            if (sts.slot_free) begin
              cmd.emit      = 1'b1;
              cmd.kind      = srrc_pkg::KIND_STATUS;
              cmd.status    = sts.port_open ? srrc_pkg::ST_IS_OPEN : srrc_pkg::ST_OK;
              cmd.last      = 1'b1;
              cmd.open_port = !sts.port_open;
              state_nxt     = S_IDLE;
            end
          end
          srrc_pkg::OP_CLOSE: begin
            if (sts.slot_free) begin
              cmd.emit       = 1'b1;
              cmd.kind       = srrc_pkg::KIND_STATUS;
              cmd.status     = sts.port_open ? srrc_pkg::ST_OK : srrc_pkg::ST_NOT_OPEN;
              cmd.last       = 1'b1;
              cmd.close_port = sts.port_open;
              state_nxt      = S_IDLE;
            end
          end
          srrc_pkg::OP_RX_BYTE: begin
            if (!sts.port_open) begin
              state_nxt = S_IDLE;
            end else if (sts.mode != srrc_pkg::MODE_READ) begin
              if (!sts.ring_full) begin
                cmd.ring_write = 1'b1;
                state_nxt      = S_IDLE;
              end else if (sts.slot_free) begin
                cmd.emit   = 1'b1;
                cmd.kind   = srrc_pkg::KIND_STATUS;
                cmd.status = srrc_pkg::ST_DROPPED;
                cmd.last   = 1'b1;
                state_nxt  = S_IDLE;
              end
            end else if (sts.rx_nl) begin
              state_nxt = S_IDLE;
            end else if (sts.slot_free) begin
              cmd.emit     = 1'b1;
              cmd.kind     = srrc_pkg::KIND_DATA;
              cmd.status   = srrc_pkg::ST_OK;
              cmd.off_sel  = srrc_pkg::OFF_DONE;
              cmd.data_sel = srrc_pkg::DAT_RX;
              cmd.last     = !sts.done_inc_reach;
              cmd.done_inc = 1'b1;
              state_nxt    = sts.done_inc_reach ? S_LIVE_FIN : S_IDLE;
            end
          end
          srrc_pkg::OP_TX_RDY: begin
            if (!sts.port_open || sts.mode != srrc_pkg::MODE_WRITE) begin
              state_nxt = S_IDLE;
            end else if (sts.slot_free) begin
              cmd.emit   = 1'b1;
              cmd.status = srrc_pkg::ST_OK;
              cmd.last   = 1'b1;
              if (sts.done_lt_wanted) begin
                cmd.kind     = srrc_pkg::KIND_FETCH;
                cmd.off_sel  = srrc_pkg::OFF_DONE;
                cmd.done_inc = 1'b1;
              end else begin
                cmd.kind    = srrc_pkg::KIND_DONE;
                cmd.cnt_sel = srrc_pkg::CNT_WANTED;
                cmd.finish  = 1'b1;
              end
              state_nxt = S_IDLE;
            end
          end
          srrc_pkg::OP_READ, srrc_pkg::OP_WRITE: begin
            if (sts.slot_free) begin
              if (!sts.port_open || sts.len_zero || sts.mode != srrc_pkg::MODE_IDLE) begin
                cmd.emit = 1'b1;
                cmd.kind = srrc_pkg::KIND_STATUS;
                cmd.last = 1'b1;
                if (!sts.port_open) begin
                  cmd.status = srrc_pkg::ST_NOT_OPEN;
                end else if (sts.len_zero) begin
                  cmd.status = srrc_pkg::ST_ZERO_LEN;
                end else begin
                  cmd.status = srrc_pkg::ST_BUSY;
                end
                state_nxt = S_IDLE;
              end else if (sts.op == srrc_pkg::OP_READ) begin
                cmd.start_read = 1'b1;
                state_nxt      = S_RD_ADDR;
              end else begin
                cmd.emit        = 1'b1;
                cmd.kind        = srrc_pkg::KIND_FETCH;
                cmd.status      = srrc_pkg::ST_OK;
                cmd.off_sel     = srrc_pkg::OFF_ZERO;
                cmd.start_write = 1'b1;
                state_nxt       = S_W_STAT;
              end
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_W_STAT: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = srrc_pkg::KIND_STATUS;
          cmd.status = srrc_pkg::ST_OK;
          cmd.last   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_LIVE_FIN: begin
        if (sts.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = srrc_pkg::KIND_DONE;
          cmd.status  = srrc_pkg::ST_OK;
          cmd.cnt_sel = srrc_pkg::CNT_DONE;
          cmd.last    = 1'b1;
          cmd.finish  = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_RD_ADDR: begin
        if (!sts.ring_empty && sts.done_lt_wanted) begin
          cmd.ring_read = 1'b1;
          state_nxt     = S_RD_DATA;
        end else if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.status = srrc_pkg::ST_OK;
          cmd.last   = 1'b1;
          if (!sts.done_lt_wanted) begin
            cmd.kind    = srrc_pkg::KIND_DONE;
            cmd.cnt_sel = srrc_pkg::CNT_DONE;
            cmd.finish  = 1'b1;
          end else begin
            cmd.kind = srrc_pkg::KIND_STATUS;
          end
          state_nxt = S_IDLE;
        end
      end
      S_RD_DATA: begin
        if (sts.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.status   = srrc_pkg::ST_OK;
          cmd.ring_pop = 1'b1;
          if (sts.mem_nl) begin
            cmd.kind    = srrc_pkg::KIND_DONE;
            cmd.cnt_sel = srrc_pkg::CNT_DONE;
            cmd.last    = 1'b1;
            cmd.finish  = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.kind     = srrc_pkg::KIND_DATA;
            cmd.off_sel  = srrc_pkg::OFF_DONE;
            cmd.data_sel = srrc_pkg::DAT_MEM;
            cmd.done_inc = 1'b1;
            state_nxt    = S_RD_ADDR;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/srrc_datapath.sv
// port state, receive ring and result register of the serial request ring controller
`default_nettype none
module srrc_datapath #(
  parameter int RING_DEPTH = srrc_pkg::RING_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [2:0]     in_op,
  input  wire logic [7:0]     in_rx_byte,
  input  wire logic [5:0]     in_req_length,
  input  wire srrc_pkg::cmd_t cmd,
  output srrc_pkg::sts_t      sts,
  input  wire logic           out_tready,
  output logic                out_tvalid,
  output logic [1:0]          out_kind,
  output logic [2:0]          out_status,
  output logic [4:0]          out_offset,
  output logic [7:0]          out_data_byte,
  output logic [5:0]          out_done_count,
  output logic                out_last
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] PTR_MAX   = AW'(RING_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(RING_DEPTH);
  localparam logic [5:0]    LEN_MAX   = 6'(srrc_pkg::MAX_REQUEST);

  logic [7:0]    ring [RING_DEPTH];
  logic [7:0]    mem_q_r;

  logic [2:0]    op_r;
  logic [7:0]    rx_r;
  logic [5:0]    len_r;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic          open_r, open_nxt;
  logic [5:0]    done_r, done_nxt;
  logic [5:0]    wanted_r, wanted_nxt;
  logic          valid_r, valid_nxt;
  logic [5:0]    done_plus;
  logic [4:0]    res_off;
  logic [7:0]    res_data;
  logic [5:0]    res_cnt;

  assign done_plus = done_r + 6'd1;

  assign sts.op             = op_r;
  assign sts.port_open      = open_r;
  assign sts.mode           = mode_r;
  assign sts.ring_empty     = (fill_r == '0);
  assign sts.ring_full      = (fill_r == FILL_FULL);
  assign sts.len_zero       = (len_r == 6'd0);
  assign sts.done_lt_wanted = (done_r < wanted_r);
  assign sts.done_inc_reach = (done_plus >= wanted_r);
  assign sts.mem_nl         = (mem_q_r == srrc_pkg::NEWLINE_CHAR);
  assign sts.rx_nl          = (rx_r == srrc_pkg::NEWLINE_CHAR);
  assign sts.slot_free      = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r  <= in_op;
      rx_r  <= in_rx_byte;
      len_r <= (in_req_length > LEN_MAX) ? LEN_MAX : in_req_length;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ring_write) begin
      ring[wptr_r] <= rx_r;
    end
    if (cmd.ring_read) begin
      mem_q_r <= ring[rptr_r];
    end
  end

  always_comb begin
    rptr_nxt   = rptr_r;
    wptr_nxt   = wptr_r;
    fill_nxt   = fill_r;
    mode_nxt   = mode_r;
    open_nxt   = open_r;
    done_nxt   = done_r;
    wanted_nxt = wanted_r;
    if (cmd.open_port) begin
      open_nxt = 1'b1;
      mode_nxt = srrc_pkg::MODE_IDLE;
      rptr_nxt = '0;
      wptr_nxt = '0;
      fill_nxt = '0;
    end
    if (cmd.close_port) begin
      open_nxt = 1'b0;
    end
    if (cmd.ring_write) begin
      wptr_nxt = (wptr_r == PTR_MAX) ? '0 : wptr_r + 1'b1;
      fill_nxt = fill_r + 1'b1;
    end
    if (cmd.ring_pop) begin
      rptr_nxt = (rptr_r == PTR_MAX) ? '0 : rptr_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end
    if (cmd.done_inc) begin
      done_nxt = done_plus;
    end
    if (cmd.start_read) begin
      done_nxt   = 6'd0;
      wanted_nxt = len_r;
      mode_nxt   = srrc_pkg::MODE_READ;
    end
    if (cmd.start_write) begin
      done_nxt   = 6'd1;
      wanted_nxt = len_r;
      mode_nxt   = srrc_pkg::MODE_WRITE;
    end
    if (cmd.finish) begin
      mode_nxt = srrc_pkg::MODE_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r   <= '0;
      wptr_r   <= '0;
      fill_r   <= '0;
      mode_r   <= srrc_pkg::MODE_IDLE;
      open_r   <= 1'b0;
      done_r   <= 6'd0;
      wanted_r <= 6'd0;
      valid_r  <= 1'b0;
    end else begin
      rptr_r   <= rptr_nxt;
      wptr_r   <= wptr_nxt;
      fill_r   <= fill_nxt;
      mode_r   <= mode_nxt;
      open_r   <= open_nxt;
      done_r   <= done_nxt;
      wanted_r <= wanted_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_comb begin
    res_off = (cmd.off_sel == srrc_pkg::OFF_DONE) ? done_r[4:0] : 5'd0;
    case (cmd.data_sel)
      srrc_pkg::DAT_RX:  res_data = rx_r;
      srrc_pkg::DAT_MEM: res_data = mem_q_r;
      default:           res_data = 8'd0;
    endcase
    case (cmd.cnt_sel)
      srrc_pkg::CNT_DONE:   res_cnt = done_r;
      srrc_pkg::CNT_WANTED: res_cnt = wanted_r;
      default:              res_cnt = 6'd0;
    endcase
  end

  assign valid_nxt = cmd.emit ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind       <= cmd.kind;
      out_status     <= cmd.status;
      out_offset     <= res_off;
      out_data_byte  <= res_data;
      out_done_count <= res_cnt;
      out_last       <= cmd.last;
    end
  end

  assign out_tvalid = valid_r;

endmodule
`default_nettype wire

### verif/tb.sv
// self-checking testbench for the serial request ring controller core
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_SLOTS = srrc_pkg::RING_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int STALL_AT = 150;
  localparam int STALL_CYCLES = 400;

  typedef struct {
    logic [2:0] op;
    logic [7:0] ch;
    logic [5:0] len;
    bit         drain_wait;
  } port_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] status;
    logic [4:0] offset;
    logic [7:0] data;
    logic [5:0] count;
    logic       last;
  } port_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  serial_request_ring_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  port_req_t    pending_reqs[$];
  port_result_t port_results_q[$];
  port_req_t    cur_req;
  int           total_reqs = 0;
  int           reqs_taken = 0;
  int           mismatches = 0;
  int           stall_left = 0;
  bit           stall_used = 1'b0;
  int unsigned  cycle_cnt = 0;
  logic         steady;

  // shadow copy of the port state
  logic [7:0] ring_copy [RING_SLOTS];
  int         rd_ptr = 0;
  int         wr_ptr = 0;
  int         ring_fill = 0;
  logic [1:0] port_mode = srrc_pkg::MODE_IDLE;
  logic       port_is_open = 1'b0;
  logic [5:0] bytes_done = '0;
  logic [5:0] bytes_wanted = '0;

  assign steady = (reqs_taken >= 40) && (reqs_taken < 110);

  function automatic port_result_t result_of(logic [1:0] kind, logic [2:0] status,
                                             logic [4:0] offset, logic [7:0] data,
                                             logic [5:0] count);
    port_result_t r;
    r = '{kind: kind, status: status, offset: offset, data: data, count: count, last: 1'b0};
    return r;
  endfunction

  function automatic logic [2:0] request_error(logic [5:0] len);
    if (!port_is_open) return srrc_pkg::ST_NOT_OPEN;
    if (len == 6'd0) return srrc_pkg::ST_ZERO_LEN;
    if (port_mode != srrc_pkg::MODE_IDLE) return srrc_pkg::ST_BUSY;
    return srrc_pkg::ST_OK;
  endfunction

  task automatic predict_port_results(port_req_t req);
    port_result_t res[$];
    logic [5:0]   len;
    logic [7:0]   b;
    logic [2:0]   err;
    bit           nl_hit;
    len = (req.len > srrc_pkg::MAX_REQUEST) ? 6'(srrc_pkg::MAX_REQUEST) : req.len;
    nl_hit = 1'b0;
    case (req.op)
      srrc_pkg::OP_OPEN: begin
        if (port_is_open) begin
          res.push_back(result_of(srrc_pkg::KIND_STATUS, srrc_pkg::ST_IS_OPEN, '0, '0, '0));
        end else begin
          port_is_open = 1'b1;
          port_mode = srrc_pkg::MODE_IDLE;
          ring_fill = 0;
          rd_ptr = 0;
          wr_ptr = 0;
          res.push_back(result_of(srrc_pkg::KIND_STATUS, srrc_pkg::ST_OK, '0, '0, '0));
        end
      end
      srrc_pkg::OP_CLOSE: begin
        if (!port_is_open) begin
          res.push_back(result_of(srrc_pkg::KIND_STATUS, srrc_pkg::ST_NOT_OPEN, '0, '0, '0));
        end else begin
          port_is_open = 1'b0;
          res.push_back(result_of(srrc_pkg::KIND_STATUS, srrc_pkg::ST_OK, '0, '0, '0));
        end
      end
      srrc_pkg::OP_RX_BYTE: begin
        if (port_is_open && port_mode != srrc_pkg::MODE_READ) begin
          if (ring_fill >= RING_SLOTS) begin
            res.push_back(result_of(srrc_pkg::KIND_STATUS, srrc_pkg::ST_DROPPED, '0, '0, '0));
          end else begin
            ring_copy[wr_ptr] = req.ch;
            wr_ptr = (wr_ptr + 1) % RING_SLOTS;
            ring_fill++;
          end
        end else if (port_is_open && req.ch != srrc_pkg::NEWLINE_CHAR) begin
          res.push_back(result_of(srrc_pkg::KIND_DATA, srrc_pkg::ST_OK, bytes_done[4:0],
                                  req.ch, '0));
          bytes_done = bytes_done + 6'd1;
          if (bytes_done >= bytes_wanted) begin
            port_mode = srrc_pkg::MODE_IDLE;
            res.push_back(result_of(srrc_pkg::KIND_DONE, srrc_pkg::ST_OK, '0, '0, bytes_done));
          end
        end
      end
      srrc_pkg::OP_TX_RDY: begin
        if (port_is_open && port_mode == srrc_pkg::MODE_WRITE) begin
          if (bytes_done < bytes_wanted) begin
            res.push_back(result_of(srrc_pkg::KIND_FETCH, srrc_pkg::ST_OK, bytes_done[4:0],
                                    '0, '0));
            bytes_done = bytes_done + 6'd1;
          end else begin
            port_mode = srrc_pkg::MODE_IDLE;
            res.push_back(result_of(srrc_pkg::KIND_DONE, srrc_pkg::ST_OK, '0, '0,
                                    bytes_wanted));
          end
        end
      end
      srrc_pkg::OP_READ: begin
        err = request_error(len);
        if (err != srrc_pkg::ST_OK) begin
          res.push_back(result_of(srrc_pkg::KIND_STATUS, err, '0, '0, '0));
        end else begin
          bytes_done = '0;
          bytes_wanted = len;
          port_mode = srrc_pkg::MODE_READ;
          while (!nl_hit && ring_fill > 0 && bytes_done < bytes_wanted) begin
            b = ring_copy[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RING_SLOTS;
            ring_fill--;
            if (b == srrc_pkg::NEWLINE_CHAR) begin
              nl_hit = 1'b1;
            end else begin
              res.push_back(result_of(srrc_pkg::KIND_DATA, srrc_pkg::ST_OK, bytes_done[4:0],
                                      b, '0));
              bytes_done = bytes_done + 6'd1;
            end
          end
          if (nl_hit || bytes_done == bytes_wanted) begin
            port_mode = srrc_pkg::MODE_IDLE;
            res.push_back(result_of(srrc_pkg::KIND_DONE, srrc_pkg::ST_OK, '0, '0, bytes_done));
          end else begin
            res.push_back(result_of(srrc_pkg::KIND_STATUS, srrc_pkg::ST_OK, '0, '0, '0));
          end
        end
      end
      srrc_pkg::OP_WRITE: begin
        err = request_error(len);
        if (err != srrc_pkg::ST_OK) begin
          res.push_back(result_of(srrc_pkg::KIND_STATUS, err, '0, '0, '0));
        end else begin
          bytes_done = 6'd1;
          bytes_wanted = len;
          port_mode = srrc_pkg::MODE_WRITE;
          res.push_back(result_of(srrc_pkg::KIND_FETCH, srrc_pkg::ST_OK, '0, '0, '0));
          res.push_back(result_of(srrc_pkg::KIND_STATUS, srrc_pkg::ST_OK, '0, '0, '0));
        end
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) port_results_q.push_back(res[i]);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void queue_req(logic [2:0] op, logic [7:0] ch, logic [5:0] len,
                                    bit drain_wait = 1'b0);
    pending_reqs.push_back('{op: op, ch: ch, len: len, drain_wait: drain_wait});
    if (!drain_wait) total_reqs++;
  endfunction

  function automatic logic [5:0] pick_len();
    int p;
    p = $urandom_range(99);
    if (p < 80) return 6'($urandom_range(1, 8));
    if (p < 90) return 6'($urandom_range(9, 32));
    return 6'($urandom_range(33, 63));
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_port_results(cur_req);
        reqs_taken <= reqs_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && pending_reqs[0].drain_wait) begin
          if (port_results_q.size() == 0) void'(pending_reqs.pop_front());
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= 31)) begin
          cur_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, cur_req.len, cur_req.ch};
          in_tuser <= cur_req.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_used <= 1'b0;
    end else if (!stall_used && reqs_taken >= STALL_AT) begin
      stall_left <= STALL_CYCLES;
      stall_used <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin : result_check
    port_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (port_results_q.size() == 0) begin
          report_mismatch("unexpected result, tdata", int'(out_tdata), 0);
        end else begin
          want = port_results_q.pop_front();
          if (out_tuser !== want.kind) report_mismatch("kind", out_tuser, want.kind);
          if (out_tdata[2:0] !== want.status)
            report_mismatch("status", out_tdata[2:0], want.status);
          if (out_tdata[7:3] !== want.offset)
            report_mismatch("offset", out_tdata[7:3], want.offset);
          if (out_tdata[15:8] !== want.data)
            report_mismatch("data_byte", out_tdata[15:8], want.data);
          if (out_tdata[21:16] !== want.count)
            report_mismatch("done_count", out_tdata[21:16], want.count);
          if (out_tlast !== want.last) report_mismatch("last", out_tlast, want.last);
        end
      end
      out_tready <= (stall_left == 0) && (steady || $urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int  p;
    int  n;
    int  burst_reqs;
    bit  burst_done;
    logic [5:0] len;

    burst_reqs = 0;
    burst_done = 1'b0;

    // closed port
    queue_req(srrc_pkg::OP_CLOSE, 8'h00, 6'd0);
    queue_req(srrc_pkg::OP_RX_BYTE, 8'h41, 6'd0);
    queue_req(srrc_pkg::OP_TX_RDY, 8'h00, 6'd0);
    queue_req(srrc_pkg::OP_READ, 8'h00, 6'd4);
    queue_req(3'd6, 8'hff, 6'd63);
    queue_req(3'd7, 8'h00, 6'd1);
    // open and request checks
    queue_req(srrc_pkg::OP_OPEN, 8'h00, 6'd0);
    queue_req(srrc_pkg::OP_OPEN, 8'h00, 6'd0);
    queue_req(srrc_pkg::OP_READ, 8'h00, 6'd0);
    queue_req(srrc_pkg::OP_WRITE, 8'h00, 6'd0);
    queue_req(srrc_pkg::OP_TX_RDY, 8'h00, 6'd0);
    // ring drain stopped by a newline, then a partial drain
    queue_req(srrc_pkg::OP_RX_BYTE, 8'h41, 6'd0);
    queue_req(srrc_pkg::OP_RX_BYTE, srrc_pkg::NEWLINE_CHAR, 6'd0);
    queue_req(srrc_pkg::OP_RX_BYTE, 8'hff, 6'd0);
    queue_req(srrc_pkg::OP_RX_BYTE, 8'h00, 6'd0);
    queue_req(srrc_pkg::OP_READ, 8'h00, 6'd63);
    queue_req(srrc_pkg::OP_READ, 8'h00, 6'd5);
    queue_req(srrc_pkg::OP_WRITE, 8'h00, 6'd3);
    queue_req(srrc_pkg::OP_RX_BYTE, srrc_pkg::NEWLINE_CHAR, 6'd0);
    queue_req(srrc_pkg::OP_RX_BYTE, 8'h80, 6'd0);
    queue_req(srrc_pkg::OP_RX_BYTE, 8'h01, 6'd0);
    queue_req(srrc_pkg::OP_RX_BYTE, 8'h7f, 6'd0);
    // write, then close with a write pending
    queue_req(srrc_pkg::OP_WRITE, 8'h00, 6'd2);
    queue_req(srrc_pkg::OP_TX_RDY, 8'h00, 6'd0);
    queue_req(srrc_pkg::OP_TX_RDY, 8'h00, 6'd0);
    queue_req(srrc_pkg::OP_WRITE, 8'h00, 6'd1);
    queue_req(srrc_pkg::OP_CLOSE, 8'h00, 6'd0);
    queue_req(srrc_pkg::OP_TX_RDY, 8'h00, 6'd0);
    queue_req(srrc_pkg::OP_OPEN, 8'h00, 6'd0);
    queue_req(srrc_pkg::OP_OPEN, 8'h00, 6'd0, 1'b1);

    while (total_reqs - burst_reqs < 180) begin
      if (!burst_done && total_reqs >= 120) begin
        // overfill the ring, then long drains
        n = total_reqs;
        queue_req(srrc_pkg::OP_CLOSE, 8'h00, 6'd0);
        queue_req(srrc_pkg::OP_OPEN, 8'h00, 6'd0);
        repeat (RING_SLOTS + 2)
          queue_req(srrc_pkg::OP_RX_BYTE, 8'($urandom_range(11, 255)), 6'd0);
        repeat (4) queue_req(srrc_pkg::OP_READ, 8'($urandom_range(255)), 6'd32);
        burst_reqs = total_reqs - n;
        burst_done = 1'b1;
      end
      p = $urandom_range(99);
      if (p < 30) begin
        len = pick_len();
        queue_req(srrc_pkg::OP_READ, 8'($urandom_range(255)), len);
        n = ((len > srrc_pkg::MAX_REQUEST) ? srrc_pkg::MAX_REQUEST : int'(len)) +
            $urandom_range(0, 2);
        repeat (n)
          queue_req(srrc_pkg::OP_RX_BYTE, ($urandom_range(9) == 0) ? srrc_pkg::NEWLINE_CHAR :
                    8'($urandom_range(255)), 6'($urandom_range(63)));
      end else if (p < 55) begin
        len = pick_len();
        queue_req(srrc_pkg::OP_WRITE, 8'($urandom_range(255)), len);
        n = ((len > srrc_pkg::MAX_REQUEST) ? srrc_pkg::MAX_REQUEST : int'(len)) + 1;
        repeat (n) begin
          if ($urandom_range(9) == 0)
            queue_req(srrc_pkg::OP_RX_BYTE, 8'($urandom_range(255)), 6'd0);
          queue_req(srrc_pkg::OP_TX_RDY, 8'($urandom_range(255)), 6'($urandom_range(63)));
        end
      end else if (p < 70) begin
        repeat ($urandom_range(1, 10))
          queue_req(srrc_pkg::OP_RX_BYTE, ($urandom_range(99) < 15) ? srrc_pkg::NEWLINE_CHAR :
                    8'($urandom_range(255)), 6'd0);
      end else if (p < 85) begin
        queue_req(3'($urandom_range(7)), 8'($urandom_range(255)), 6'($urandom_range(63)));
        if (pending_reqs[pending_reqs.size() - 1].op == srrc_pkg::OP_CLOSE &&
            $urandom_range(9) < 8)
          queue_req(srrc_pkg::OP_OPEN, 8'h00, 6'd0);
      end else if (p < 93) begin
        queue_req(srrc_pkg::OP_CLOSE, 8'h00, 6'd0);
        queue_req(srrc_pkg::OP_OPEN, 8'h00, 6'd0);
      end else begin
        queue_req(srrc_pkg::OP_OPEN, 8'h00, 6'd0, 1'b1);
      end
    end

    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (reqs_taken != total_reqs || port_results_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
